// ----- hdl/mse_pkg.sv -----
// Package for the Mandelbrot smooth escape block: default parameters, fixed-point
// constants, configuration register indexes and the sequencer state type.
// No dependencies; the top level uses it by scoped names.
package mse_pkg;

	localparam int COORD_FRAC_BITS_DEF = 28;
	localparam int MAX_SIDE_DEF        = 4096;

	// Logarithm fraction bits and ln 2 in Q.30.
	localparam int LOG_FRAC = 24;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Normalized mantissa used by the bit-serial log2.
	localparam int MANT_W = 31;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd5;

	localparam int IDX_W   = 12;
	localparam int COUNT_W = 16;
	localparam int MU_W    = 33;
	localparam int MU_ST_W = 34;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_GO,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_Z_GO,
		ST_Z_MUL,
		ST_Z_CHK,
		ST_L_NORM,
		ST_L_GO,
		ST_L_MUL,
		ST_LN_GO,
		ST_LN_MUL,
		ST_MU,
		ST_FIN
	} mse_state_t;

endpackage

// ----- hdl/mse_mul.sv -----
// Shared unsigned multiplier for the Mandelbrot smooth escape block.
// Forms one full product from four half-width partial products.
// Depends on nothing but its parameter.
module mse_mul #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [4*((MW+1)/2)-1:0] prod
);

	localparam int H  = (MW + 1) / 2;
	localparam int PR = 4 * H;

	logic [2*H-1:0] a_q, b_q;
	logic [PR-1:0]  acc_q;
	logic [1:0]     k_q;
	logic           busy_q, done_q;
	logic [H-1:0]   op_a, op_b;
	logic [2*H-1:0] pp;
	logic [PR-1:0]  pp_sh;

	always_comb begin
		op_a = k_q[1] ? a_q[2*H-1:H] : a_q[H-1:0];
		op_b = k_q[0] ? b_q[2*H-1:H] : b_q[H-1:0];
		pp   = op_a * op_b;
		case (k_q)
			2'd0:    pp_sh = PR'(pp);
			2'd3:    pp_sh = PR'(pp) << (2 * H);
			default: pp_sh = PR'(pp) << H;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q    <= 2'd0;
		end else if (busy_q) begin
			k_q <= k_q + 2'd1;
			if (k_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= (2*H)'(a);
			b_q   <= (2*H)'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- hdl/mse_div.sv -----
// Restoring divider for the pixel-to-window mapping, one quotient bit per cycle.
// Depends on nothing but its parameters.
module mse_div #(
	parameter int DW = 44,
	parameter int SW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quot_q;
	logic [SW-1:0] rem_q, div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [SW:0]   trial, diff;
	logic          qbit;

	always_comb begin
		trial = {rem_q, quot_q[DW-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DW-2:0], qbit};
			rem_q  <= qbit ? diff[SW-1:0] : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/mandelbrot_smooth_escape.sv -----
// Top level of the Mandelbrot smooth escape block: configuration registers,
// sequencer, running minimum and maximum, output register.
// Depends on mse_pkg, mse_mul and mse_div.
//
// Channel   Direction  Content
// s_axis    in         tdata: pixel_col[11:0], pixel_row[23:12]
// m_axis    out        tdata: iteration_count, smooth_value, lowest_smooth,
//                      highest_smooth; tuser: escaped
// cfg       in         write enable, register index, 32-bit data
//
// One pixel is accepted, then mapped to the window on both axes (per axis a
// multiply and a divide), then iterated (each escape iteration takes three
// products and a check), then passes the two bit-serial logarithms when the
// pixel escapes. The shared multiplier paces each iteration; the iteration count
// sets the total time.
// Reset clears the configuration to its defaults and the running range.
// A new pixel transfer is taken only when the sequencer is idle; a finished
// result waits in the output register while the next pixel is already at work.
module mandelbrot_smooth_escape #(
	parameter int COORD_FRAC_BITS = mse_pkg::COORD_FRAC_BITS_DEF,
	parameter int MAX_SIDE        = mse_pkg::MAX_SIDE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // pixel_col, pixel_row
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,   // iteration_count, smooth_value,
	                                     // lowest_smooth, highest_smooth, zero pad
	output logic [0:0]   m_axis_tuser,   // escaped
	input  logic         cfg_write,
	input  logic [mse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mse_pkg::CFG_W-1:0]     cfg_data
);

	localparam int F    = COORD_FRAC_BITS;
	localparam int LF   = mse_pkg::LOG_FRAC;
	localparam int MW   = (F + 5 > 32) ? F + 5 : 32;    // multiplier operand
	localparam int PRW  = 4 * ((MW + 1) / 2);           // multiplier product
	localparam int ZW   = F + 6;                        // z and c parts
	localparam int PW   = F + 11;                       // truncated products
	localparam int NW   = F + 11;                       // |z|^2 and log input
	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int DW   = 32 + mse_pkg::IDX_W;
	localparam int MPW  = ((DW > F + 5) ? DW : F + 5) + 2;
	localparam int SCW  = $clog2(NW);
	localparam int MTW  = mse_pkg::MANT_W;
	localparam int TW   = mse_pkg::COUNT_W + 1 + LF + 2;

	localparam logic signed [MPW-1:0] CLIM = MPW'(1) << (F + 4);
	localparam logic [NW-1:0]         FOUR = NW'(4) << F;

	// Configuration registers.
	logic signed [31:0] center_re_q, center_im_q;
	logic [30:0]        hs_q;
	logic [12:0]        cols_q, rows_q;
	logic [15:0]        lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q <= '0;
			center_im_q <= '0;
			hs_q        <= 31'(64'd1 << (F - 1));
			cols_q      <= 13'd512;
			rows_q      <= 13'd512;
			lim_q       <= 16'd110;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mse_pkg::REG_CENTER_REAL: center_re_q <= cfg_data;
				mse_pkg::REG_CENTER_IMAG: center_im_q <= cfg_data;
				mse_pkg::REG_HALF_SPAN:   hs_q        <= cfg_data[30:0];
				mse_pkg::REG_COLUMNS:     cols_q      <= cfg_data[12:0];
				mse_pkg::REG_ROWS:        rows_q      <= cfg_data[12:0];
				mse_pkg::REG_ITER_LIMIT:  lim_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mse_pkg::mse_state_t state_q, state_d;

	// Datapath registers.
	logic [11:0]            col_q, row_q;
	logic                   axis_q;
	logic signed [ZW-1:0]   cr_q, ci_q, x_q, y_q;
	logic signed [PW-1:0]   xx_q, yy_q, xy_q;
	logic [15:0]            n_q;
	logic [1:0]             k_q;
	logic [NW-1:0]          norm_q;
	logic [SCW-1:0]         sc_q;
	logic [MTW-1:0]         mant_q;
	logic [LF-1:0]          frac_q;
	logic [4:0]             step_q;
	logic                   lpass_q;
	logic [31:0]            l2m_q, l2ln_q;
	logic                   esc_q;
	logic signed [mse_pkg::MU_ST_W-1:0] mu_q, min_q, max_q;

	// Output register.
	logic                   ov_q;
	logic [15:0]            o_cnt_q;
	logic                   o_esc_q;
	logic [mse_pkg::MU_W-1:0] o_mu_q, o_lo_q, o_hi_q;

	// Shared units.
	logic            mul_start, mul_done, div_start, div_done;
	logic [MW-1:0]   mul_a, mul_b;
	logic [PRW-1:0]  prod;
	logic [DW-1:0]   quot;
	logic [SW-1:0]   side;

	mse_mul #(.MW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod)
	);

	mse_div #(.DW(DW), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod[DW-1:0]),
		.divisor(side), .done(div_done), .quot(quot)
	);

	// Combinational helpers.
	logic [12:0]           side_raw;
	logic [ZW-1:0]         ax, ay;
	logic [F+9:0]          zr;
	logic                  zneg;
	logic [NW-1:0]         mag;
	logic signed [PW-1:0]  nx, ny;
	logic                  cont;
	logic signed [MPW-1:0] pmap;
	logic signed [ZW-1:0]  csat;
	logic [31:0]           sq;
	logic                  sqbit;
	logic [LF-1:0]         frac_next;
	logic [7:0]            expo;
	logic [31:0]           l2_new;
	logic [PRW-1:0]        ln_sum;
	logic [31:0]           lnm;
	logic signed [TW-1:0]  tmu;
	logic signed [mse_pkg::MU_ST_W-1:0] mu_new;
	logic                  fin_go;

	always_comb begin
		side_raw = axis_q ? rows_q : cols_q;
		if (side_raw == 13'd0)
			side = SW'(1);
		else if (32'(side_raw) > 32'(MAX_SIDE))
			side = SW'(MAX_SIDE);
		else
			side = SW'(side_raw);

		// Window position, extrapolated off the image and saturated to [-16, 16).
		pmap = MPW'(axis_q ? center_im_q : center_re_q) - MPW'(hs_q) + MPW'(quot);
		if (pmap < -CLIM)
			csat = ZW'(-CLIM);
		else if (pmap > CLIM - MPW'(1))
			csat = ZW'(CLIM - MPW'(1));
		else
			csat = ZW'(pmap);

		ax   = x_q[ZW-1] ? ZW'(-x_q) : ZW'(x_q);
		ay   = y_q[ZW-1] ? ZW'(-y_q) : ZW'(y_q);
		zr   = prod[F +: F + 10];
		zneg = x_q[ZW-1] ^ y_q[ZW-1];

		mag  = NW'(xx_q) + NW'(yy_q);
		nx   = xx_q - yy_q + PW'(cr_q);
		ny   = (xy_q <<< 1) + PW'(ci_q);
		cont = (mag <= FOUR) && (n_q < lim_q);

		sq        = prod[30 +: 32];
		sqbit     = sq[31];
		frac_next = {frac_q[LF-2:0], sqbit};
		expo      = 8'(NW - 1 - int'(sc_q) - (lpass_q ? LF : F));
		l2_new    = {expo, frac_next};

		ln_sum = prod + PRW'(64'd1 << 29);
		lnm    = ln_sum[30 +: 32];

		// Smooth count with round to nearest at Q16.16.
		tmu    = (TW'({1'b0, n_q} + 17'd1) <<< LF) - TW'(l2ln_q) + TW'(1 << (LF - 17));
		mu_new = mse_pkg::MU_ST_W'(tmu >>> (LF - 16));

		fin_go = !ov_q || m_axis_tready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mse_pkg::ST_IDLE:    if (s_axis_tvalid) state_d = mse_pkg::ST_MAP_GO;
			mse_pkg::ST_MAP_GO:  state_d = mse_pkg::ST_MAP_MUL;
			mse_pkg::ST_MAP_MUL: if (mul_done) state_d = mse_pkg::ST_MAP_DIV;
			mse_pkg::ST_MAP_DIV: begin
				if (div_done)
					state_d = axis_q ? mse_pkg::ST_Z_CHK : mse_pkg::ST_MAP_GO;
			end
			mse_pkg::ST_Z_GO:    state_d = mse_pkg::ST_Z_MUL;
			mse_pkg::ST_Z_MUL: begin
				if (mul_done)
					state_d = (k_q == 2'd2) ? mse_pkg::ST_Z_CHK : mse_pkg::ST_Z_GO;
			end
			mse_pkg::ST_Z_CHK: begin
				if (cont)
					state_d = mse_pkg::ST_Z_GO;
				else if (n_q < lim_q)
					state_d = mse_pkg::ST_L_NORM;
				else
					state_d = mse_pkg::ST_FIN;
			end
			mse_pkg::ST_L_NORM:  if (norm_q[NW-1]) state_d = mse_pkg::ST_L_GO;
			mse_pkg::ST_L_GO:    state_d = mse_pkg::ST_L_MUL;
			mse_pkg::ST_L_MUL: begin
				if (mul_done) begin
					if (step_q == 5'(LF - 1))
						state_d = lpass_q ? mse_pkg::ST_MU : mse_pkg::ST_LN_GO;
					else
						state_d = mse_pkg::ST_L_GO;
				end
			end
			mse_pkg::ST_LN_GO:   state_d = mse_pkg::ST_LN_MUL;
			mse_pkg::ST_LN_MUL:  if (mul_done) state_d = mse_pkg::ST_L_NORM;
			mse_pkg::ST_MU:      state_d = mse_pkg::ST_FIN;
			mse_pkg::ST_FIN:     if (fin_go) state_d = mse_pkg::ST_IDLE;
			default:             state_d = mse_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: unit starts, multiplier operand selection and input ready.
	always_comb begin
		mul_start     = 1'b0;
		div_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			mse_pkg::ST_IDLE: s_axis_tready = 1'b1;
			mse_pkg::ST_MAP_GO: begin
				mul_start = 1'b1;
				mul_a     = MW'({hs_q, 1'b0});
				mul_b     = MW'(axis_q ? row_q : col_q);
			end
			mse_pkg::ST_MAP_MUL: div_start = mul_done;
			mse_pkg::ST_Z_GO: begin
				mul_start = 1'b1;
				mul_a     = MW'((k_q == 2'd1) ? ay : ax);
				mul_b     = MW'((k_q == 2'd0) ? ax : ay);
			end
			mse_pkg::ST_L_GO: begin
				mul_start = 1'b1;
				mul_a     = MW'(mant_q);
				mul_b     = MW'(mant_q);
			end
			mse_pkg::ST_LN_GO: begin
				mul_start = 1'b1;
				mul_a     = MW'(l2m_q);
				mul_b     = MW'(mse_pkg::LN2_Q30);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::ST_IDLE;
			min_q   <= mse_pkg::MU_ST_W'(110) <<< 16;
			max_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mse_pkg::ST_IDLE && s_axis_tvalid &&
			    s_axis_tdata[23:0] == 24'd0) begin
				// Frame start clears the running range.
				min_q <= mse_pkg::MU_ST_W'(lim_q) <<< 16;
				max_q <= '0;
			end
			if (state_q == mse_pkg::ST_MU) begin
				if (mu_new < min_q) min_q <= mu_new;
				if (mu_new > max_q) max_q <= mu_new;
			end
			if (state_q == mse_pkg::ST_FIN && fin_go)
				ov_q <= 1'b1;
			else if (m_axis_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mse_pkg::ST_IDLE: begin
				col_q  <= s_axis_tdata[11:0];
				row_q  <= s_axis_tdata[23:12];
				axis_q <= 1'b0;
				x_q    <= '0;
				y_q    <= '0;
				xx_q   <= '0;
				yy_q   <= '0;
				xy_q   <= '0;
				n_q    <= '0;
				k_q    <= '0;
			end
			mse_pkg::ST_MAP_DIV: begin
				if (div_done) begin
					if (axis_q) ci_q <= csat;
					else        cr_q <= csat;
					axis_q <= 1'b1;
				end
			end
			mse_pkg::ST_Z_MUL: begin
				if (mul_done) begin
					unique case (k_q)
						2'd0:    xx_q <= PW'(zr);
						2'd1:    yy_q <= PW'(zr);
						default: xy_q <= zneg ? -PW'(zr) : PW'(zr);
					endcase
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
			end
			mse_pkg::ST_Z_CHK: begin
				if (cont) begin
					x_q <= ZW'(nx);
					y_q <= ZW'(ny);
					n_q <= n_q + 16'd1;
				end else begin
					esc_q   <= (n_q < lim_q);
					mu_q    <= '0;
					norm_q  <= mag;
					sc_q    <= '0;
					lpass_q <= 1'b0;
				end
			end
			mse_pkg::ST_L_NORM: begin
				if (norm_q[NW-1]) begin
					mant_q <= norm_q[NW-1 -: MTW];
					frac_q <= '0;
					step_q <= '0;
				end else begin
					norm_q <= norm_q << 1;
					sc_q   <= sc_q + SCW'(1);
				end
			end
			mse_pkg::ST_L_MUL: begin
				if (mul_done) begin
					mant_q <= sqbit ? sq[MTW:1] : sq[MTW-1:0];
					frac_q <= frac_next;
					step_q <= step_q + 5'd1;
					if (step_q == 5'(LF - 1)) begin
						if (lpass_q) l2ln_q <= l2_new;
						else         l2m_q  <= l2_new;
					end
				end
			end
			mse_pkg::ST_LN_MUL: begin
				if (mul_done) begin
					norm_q  <= NW'(lnm);
					sc_q    <= '0;
					lpass_q <= 1'b1;
				end
			end
			mse_pkg::ST_MU: mu_q <= mu_new;
			mse_pkg::ST_FIN: begin
				if (fin_go) begin
					o_cnt_q <= n_q;
					o_esc_q <= esc_q;
					o_mu_q  <= mu_q[mse_pkg::MU_W-1:0];
					o_lo_q  <= min_q[mse_pkg::MU_W-1:0];
					o_hi_q  <= max_q[mse_pkg::MU_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {5'd0, o_hi_q, o_lo_q, o_mu_q, o_cnt_q};
	assign m_axis_tuser  = o_esc_q;

endmodule
